// ===== design/ecv_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the
// ellipsoid column voxelizer. No dependencies.
`timescale 1ns / 1ps

package ecv_pkg;

  // Sizing of the column walk and of the fixed-point format.
  localparam int MAX_SAMPLES   = 1024;
  localparam int FRACTION_BITS = 28;

  localparam int IDX_W   = $clog2(MAX_SAMPLES);
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int COORD_W = 32;
  // Exact start + i*step without wrap for every sample index.
  localparam int ACC_W   = COORD_W + IDX_W + 1;
  localparam int MAG_W   = FRACTION_BITS;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;

  // Field widths of the stream items and registers.
  localparam int XZ_W        = 26;
  localparam int FIRST_Y_W   = 21;
  localparam int MIN_Y_W     = 22;
  localparam int HEIGHT_W    = 11;
  localparam int COUNT_W     = 11;
  localparam int S_DATA_W    = 152;
  localparam int M_DATA_W    = 88;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Fixed-point constants: 0.5 and -0.5 in coordinate units, 0.25 squared.
  localparam logic signed [ACC_W-1:0] HALF     = ACC_W'(64'd1 << (FRACTION_BITS - 1));
  localparam logic signed [ACC_W-1:0] NEG_HALF = -HALF;
  localparam logic [SUM_W-1:0]        LIMIT    = SUM_W'(64'd1 << (2 * FRACTION_BITS - 2));

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_U       = 3'd0,
    REG_STEP_V       = 3'd1,
    REG_STEP_W       = 3'd2,
    REG_FIRST_Y      = 3'd3,
    REG_SAMPLE_COUNT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]   step_u;
    logic signed [COORD_W-1:0]   step_v;
    logic signed [COORD_W-1:0]   step_w;
    logic signed [FIRST_Y_W-1:0] first_y;
    logic [COUNT_W-1:0]          sample_count;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic capture;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_done;
    logic run_done;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/ellipsoid_column_voxelizer.sv =====
// Top level of the ellipsoid column voxelizer: stream ports, configuration port
// and the controller, datapath and register file. Depends on ecv_pkg.
`timescale 1ns / 1ps

// One column is taken at a time. After the item is accepted the block walks
// the column one sample per cycle through the position accumulators and a
// registered squaring stage, stopping at the first outside sample after the
// first inside run. The sample count is clamped to 1024. When the walk stops
// at an outside sample, one more sample is already in flight when the stop is
// seen. A result still waiting in the output register holds off the capture of
// the next one until it is taken. The next column can be accepted in the cycle
// after capture. Registers must be written only while the block is idle; the
// block itself does not enforce this.

module ellipsoid_column_voxelizer (
  input  logic                            clk,
  input  logic                            rst,
  // Fields from bit 0: column_x, column_z, start_u, start_v, start_w, zero pad.
  input  logic [ecv_pkg::S_DATA_W-1:0]    s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: box_x, box_base_y, box_z, box_height, zero pad.
  output logic [ecv_pkg::M_DATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0: hit.
  output logic                            m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ecv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ecv_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ecv_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration registers.
  ecv_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer.
  ecv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Column walk and result.
  ecv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_hit   (m_axis_tuser)
  );

endmodule

// ===== design/ecv_cfg_regs.sv =====
// Configuration register file of the ellipsoid column voxelizer.
// Depends on ecv_pkg.
`timescale 1ns / 1ps

module ecv_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ecv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ecv_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ecv_pkg::cfg_t                   cfg
);
  import ecv_pkg::*;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_u       <= '0;
      cfg.step_v       <= '0;
      cfg.step_w       <= '0;
      cfg.first_y      <= '0;
      cfg.sample_count <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_U:       cfg.step_u       <= cfg_data[COORD_W-1:0];
        REG_STEP_V:       cfg.step_v       <= cfg_data[COORD_W-1:0];
        REG_STEP_W:       cfg.step_w       <= cfg_data[COORD_W-1:0];
        REG_FIRST_Y:      cfg.first_y      <= cfg_data[FIRST_Y_W-1:0];
        REG_SAMPLE_COUNT: cfg.sample_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ecv_datapath.sv =====
// Datapath of the ellipsoid column voxelizer: position accumulators, squaring
// stage, run tracking and result register. Depends on ecv_pkg.
`timescale 1ns / 1ps

module ecv_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  ecv_pkg::cfg_t                cfg,
  input  ecv_pkg::ctrl_cmd_t           cmd,
  output ecv_pkg::dp_status_t          status,
  input  logic [ecv_pkg::S_DATA_W-1:0] in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ecv_pkg::M_DATA_W-1:0] out_data,
  output logic                         out_hit
);
  import ecv_pkg::*;

  logic signed [ACC_W-1:0]   acc [3];
  logic signed [ACC_W-1:0]   step [3];
  logic signed [ACC_W-1:0]   start [3];
  logic [CNT_W-1:0]          issue_idx;
  logic [CNT_W-1:0]          count;
  logic signed [XZ_W-1:0]    col_x;
  logic signed [XZ_W-1:0]    col_z;

  logic [MAG_W-1:0]          mag [3];
  logic [ACC_W-1:0]          abs_val [3];
  logic [2:0]                in_range;

  logic [SQ_W-1:0]           sq [3];
  logic                      s1_valid;
  logic                      s1_in_range;
  logic [IDX_W-1:0]          s1_idx;
  logic [SUM_W-1:0]          sq_sum;
  logic                      sample_in;

  logic                      run_found;
  logic                      run_done;
  logic [IDX_W-1:0]          run_first;
  logic [IDX_W-1:0]          run_last;

  logic signed [MIN_Y_W-1:0] min_y;
  logic [HEIGHT_W-1:0]       height;

  // Sign-extended steps and start point of the column.
  assign step[0]  = ACC_W'(cfg.step_u);
  assign step[1]  = ACC_W'(cfg.step_v);
  assign step[2]  = ACC_W'(cfg.step_w);
  assign start[0] = ACC_W'($signed(in_data[83:52]));
  assign start[1] = ACC_W'($signed(in_data[115:84]));
  assign start[2] = ACC_W'($signed(in_data[147:116]));

  // Sample count clamped to the largest column.
  always_comb begin
    if (int'(cfg.sample_count) > MAX_SAMPLES) begin
      count = CNT_W'(MAX_SAMPLES);
    end else begin
      count = CNT_W'(cfg.sample_count);
    end
  end

  // Range test and magnitude of each coordinate of the current sample.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_range[k] = (acc[k] <= HALF) && (acc[k] >= NEG_HALF);
      abs_val[k]  = acc[k][ACC_W-1] ? ACC_W'(-acc[k]) : ACC_W'(acc[k]);
      mag[k]      = abs_val[k][MAG_W-1:0];
    end
  end

  // Accumulators step once per issued sample.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        acc[k] <= start[k];
      end
      col_x <= in_data[25:0];
      col_z <= in_data[51:26];
    end else if (cmd.issue) begin
      for (int k = 0; k < 3; k++) begin
        acc[k] <= acc[k] + step[k];
      end
    end
  end

  // Squaring stage, one sample per cycle.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= mag[k] * mag[k];
      end
      s1_in_range <= &in_range;
      s1_idx      <= issue_idx[IDX_W-1:0];
    end
  end

  // Sum of squares against 0.25.
  assign sq_sum    = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  assign sample_in = s1_in_range && (sq_sum <= LIMIT);

  // Sample counter, stage valid and first-run tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      s1_valid  <= 1'b0;
      run_found <= 1'b0;
      run_done  <= 1'b0;
      run_first <= '0;
      run_last  <= '0;
    end else if (cmd.load) begin
      issue_idx <= '0;
      s1_valid  <= 1'b0;
      run_found <= 1'b0;
      run_done  <= 1'b0;
      run_first <= '0;
      run_last  <= '0;
    end else begin
      s1_valid <= cmd.issue;
      if (cmd.issue) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
      // Samples that trail the end of the first run are ignored.
      if (s1_valid && !run_done) begin
        if (sample_in) begin
          if (!run_found) begin
            run_found <= 1'b1;
            run_first <= s1_idx;
          end
          run_last <= s1_idx;
        end else if (run_found) begin
          run_done <= 1'b1;
        end
      end
    end
  end

  assign status.count_done = (issue_idx == count);
  assign status.run_done   = run_done;
  assign status.pipe_busy  = s1_valid;
  assign status.out_free   = !out_valid || out_ready;

  // Box of the first run.
  assign min_y  = MIN_Y_W'(cfg.first_y) + MIN_Y_W'(run_first);
  assign height = HEIGHT_W'(run_last) - HEIGHT_W'(run_first) + HEIGHT_W'(1);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_hit <= run_found;
      if (run_found) begin
        out_data <= {3'b000, height, col_z, min_y, col_x};
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule

// ===== design/ecv_ctrl.sv =====
// Controller of the ellipsoid column voxelizer: sequences load, sample walk
// and result capture. Depends on ecv_pkg.
`timescale 1ns / 1ps

module ecv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ecv_pkg::dp_status_t status,
  output ecv_pkg::ctrl_cmd_t  cmd
);
  import ecv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.issue   = 1'b0;
    cmd.capture = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.issue = !status.count_done && !status.run_done;
        if ((status.count_done || status.run_done) && !status.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/ecv_checker.sv =====
// Port-level checks for the ellipsoid column voxelizer, bound to the top level.
// Depends on ecv_pkg.
`timescale 1ns / 1ps

module ecv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [ecv_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready
);
  import ecv_pkg::*;

  // A result without a hit carries an all-zero box.
  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("no-hit result with nonzero box");

  // A hit has a run length between one and the largest column.
  a_hit_height: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata[84:74] != '0) && (int'(m_axis_tdata[84:74]) <= MAX_SAMPLES)))
    else $error("hit with impossible height");

  // Only one column is walked at a time.
  a_one_column: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a column is being walked");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind ellipsoid_column_voxelizer ecv_checker u_ecv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
